// ===== rtl/wpsu_pkg.sv =====
// shared types and constants for the wav pcm sample unpacker
package wpsu_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_AUDIO_FORMAT    = 2'd0,
        CFG_CHANNEL_COUNT   = 2'd1,
        CFG_BITS_PER_SAMPLE = 2'd2,
        CFG_DATA_LENGTH     = 2'd3
    } wpsu_cfg_idx_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_END_OF_DATA   = 2'd1,
        STATUS_UNSUPPORTED   = 2'd2,
        STATUS_UNKNOWN_DEPTH = 2'd3
    } wpsu_status_t;

    // input item kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REWIND = 1'b1;

    // header values that are decoded
    localparam logic [15:0] FORMAT_PCM      = 16'd1;
    localparam logic [15:0] CHANNELS_STEREO = 16'd2;
    localparam logic [15:0] BPS_8           = 16'd8;
    localparam logic [15:0] BPS_16          = 16'd16;
    localparam logic [15:0] BPS_24          = 16'd24;

    // offset-binary conversion flips the sign bit
    localparam logic [15:0] SIGN_FLIP = 16'h8000;

    // register reset values
    localparam logic [15:0] AUDIO_FORMAT_RST    = 16'd1;
    localparam logic [15:0] CHANNEL_COUNT_RST   = 16'd2;
    localparam logic [15:0] BITS_PER_SAMPLE_RST = 16'd16;
    localparam logic [31:0] DATA_LENGTH_RST     = 32'd0;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    typedef struct packed {
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
    } wpsu_cfg_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } wpsu_item_t;

    typedef struct packed {
        wpsu_status_t status;
        logic [15:0]  right_sample;
        logic [15:0]  left_sample;
    } wpsu_result_t;

endpackage

// ===== rtl/wav_pcm_sample_unpacker.sv =====
// top level of the wav pcm sample unpacker
//
// Takes the data chunk of a wav file one byte per transfer on the s_ channel
// (s_tdata is the byte, s_tuser high asks for a rewind to the start of data)
// and gives one transfer on the m_ channel per finished frame: left and right
// as unsigned 16-bit dac values plus a status code. Each data byte past the
// programmed data length, or under an unsupported format or unknown depth,
// also gives one transfer with that status and zero samples.
// Header values must be written on the cfg_ port while the stream is idle;
// the block does not enforce this. Throughput is one byte per clock while
// the output does not stall. A result passes the input register, then the
// result register loaded by the assembly logic. The frame position and a
// 32-bit byte count are updated as the byte leaves the input register, so
// every accepted byte is fully processed before the next.
// Reset clears the stream state and both stage valids, and loads the header
// defaults (pcm, stereo, 16 bit, zero length). When m_tready stays low the
// result register holds, the input register fills, and s_tready drops.
module wav_pcm_sample_unpacker (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [wpsu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wpsu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // byte input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] data_byte
    input  logic                             s_tuser,  // [0] kind
    // sample output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] left_sample, [31:16] right_sample, [33:32] status, [39:34] zero
    output logic [39:0]                      m_tdata
);

    wpsu_pkg::wpsu_cfg_t    cfg;
    wpsu_pkg::wpsu_item_t   s_item;
    wpsu_pkg::wpsu_item_t   item;
    wpsu_pkg::wpsu_result_t result;
    logic                   item_valid;
    logic                   take;

    assign s_item.kind      = s_tuser;
    assign s_item.data_byte = s_tdata;

    wpsu_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wpsu_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    wpsu_frame_asm u_frame_asm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result     (result)
    );

    // pack the result fields from the lowest bit up
    assign m_tdata = {6'd0, result.status, result.right_sample, result.left_sample};

endmodule

// ===== rtl/wpsu_cfg_regs.sv =====
// configuration register file written through the plain write port
module wpsu_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [wpsu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wpsu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output wpsu_pkg::wpsu_cfg_t                 cfg
);

    wpsu_pkg::wpsu_cfg_t cfg_reg;
    wpsu_pkg::wpsu_cfg_t cfg_next;

    // decode the register index
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                wpsu_pkg::CFG_AUDIO_FORMAT:    cfg_next.audio_format    = cfg_wdata[15:0];
                wpsu_pkg::CFG_CHANNEL_COUNT:   cfg_next.channel_count   = cfg_wdata[15:0];
                wpsu_pkg::CFG_BITS_PER_SAMPLE: cfg_next.bits_per_sample = cfg_wdata[15:0];
                wpsu_pkg::CFG_DATA_LENGTH:     cfg_next.data_length     = cfg_wdata[31:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.audio_format    <= wpsu_pkg::AUDIO_FORMAT_RST;
            cfg_reg.channel_count   <= wpsu_pkg::CHANNEL_COUNT_RST;
            cfg_reg.bits_per_sample <= wpsu_pkg::BITS_PER_SAMPLE_RST;
            cfg_reg.data_length     <= wpsu_pkg::DATA_LENGTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/wpsu_in_reg.sv =====
// input register stage that holds one accepted byte transfer
module wpsu_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wpsu_pkg::wpsu_item_t s_item,
    input  logic                 take,
    output logic                 item_valid,
    output wpsu_pkg::wpsu_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    wpsu_pkg::wpsu_item_t item_reg;

    // free slot, or the held item leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/wpsu_frame_asm.sv =====
// frame assembly state, sample conversion and result register
module wpsu_frame_asm (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  wpsu_pkg::wpsu_cfg_t    cfg,
    input  logic                   item_valid,
    input  wpsu_pkg::wpsu_item_t   item,
    output logic                   take,
    output logic                   m_valid,
    input  logic                   m_ready,
    output wpsu_pkg::wpsu_result_t result
);

    logic [31:0] byte_pos_reg,   byte_pos_next;
    logic [2:0]  frame_idx_reg,  frame_idx_next;
    logic [15:0] left_hold_reg,  left_hold_next;
    logic [15:0] right_hold_reg, right_hold_next;
    logic        m_valid_reg,    m_valid_next;
    wpsu_pkg::wpsu_result_t result_reg, result_next;

    logic        fire;
    logic        has_result;
    logic [1:0]  sample_bytes;
    logic        stereo;
    logic [2:0]  frame_bytes;
    logic [1:0]  sample_off;
    logic        to_right;
    logic        low_byte;
    logic        high_byte;
    logic [15:0] hold_cur;
    logic [15:0] hold_new;
    logic        frame_done;
    logic [15:0] left_out;
    logic [15:0] right_out;

    // output slot is free or drains this cycle
    assign take = !m_valid_reg || m_ready;
    assign fire = item_valid && take;

    // frame geometry from the header registers
    always_comb begin
        case (cfg.bits_per_sample)
            wpsu_pkg::BPS_8:  sample_bytes = 2'd1;
            wpsu_pkg::BPS_16: sample_bytes = 2'd2;
            wpsu_pkg::BPS_24: sample_bytes = 2'd3;
            default:          sample_bytes = 2'd0;
        endcase
        stereo      = (cfg.channel_count == wpsu_pkg::CHANNELS_STEREO);
        frame_bytes = stereo ? {sample_bytes, 1'b0} : {1'b0, sample_bytes};
    end

    // byte offset inside the current sample
    always_comb begin
        case (sample_bytes)
            2'd2: sample_off = {1'b0, frame_idx_reg[0]};
            2'd3: begin
                case (frame_idx_reg)
                    3'd0, 3'd3, 3'd6: sample_off = 2'd0;
                    3'd1, 3'd4, 3'd7: sample_off = 2'd1;
                    default:          sample_off = 2'd2;
                endcase
            end
            default: sample_off = 2'd0;
        endcase
        to_right  = stereo && (frame_idx_reg >= {1'b0, sample_bytes});
        // 24-bit keeps the upper two bytes of each sample
        low_byte  = ((sample_bytes == 2'd2) && (sample_off == 2'd0)) ||
                    ((sample_bytes == 2'd3) && (sample_off == 2'd1));
        high_byte = ((sample_bytes == 2'd2) && (sample_off == 2'd1)) ||
                    ((sample_bytes == 2'd3) && (sample_off == 2'd2));
    end

    // merge the byte into the selected hold
    always_comb begin
        hold_cur = to_right ? right_hold_reg : left_hold_reg;
        hold_new = hold_cur;
        if (sample_bytes == 2'd1) begin
            hold_new = {item.data_byte, 8'h00};
        end else if (low_byte) begin
            hold_new = {hold_cur[15:8], item.data_byte};
        end else if (high_byte) begin
            hold_new = {item.data_byte, hold_cur[7:0]};
        end
    end

    assign frame_done = ({1'b0, frame_idx_reg} + 4'd1) >= {1'b0, frame_bytes};

    // state update and result for one item
    always_comb begin
        byte_pos_next   = byte_pos_reg;
        frame_idx_next  = frame_idx_reg;
        left_hold_next  = left_hold_reg;
        right_hold_next = right_hold_reg;
        has_result      = 1'b0;
        result_next.left_sample  = 16'd0;
        result_next.right_sample = 16'd0;
        result_next.status       = wpsu_pkg::STATUS_OK;
        left_out  = 16'd0;
        right_out = 16'd0;
        if (item.kind == wpsu_pkg::KIND_REWIND) begin
            byte_pos_next   = 32'd0;
            frame_idx_next  = 3'd0;
            left_hold_next  = 16'd0;
            right_hold_next = 16'd0;
        end else if (byte_pos_reg >= cfg.data_length) begin
            has_result         = 1'b1;
            result_next.status = wpsu_pkg::STATUS_END_OF_DATA;
        end else if (sample_bytes == 2'd0) begin
            has_result         = 1'b1;
            byte_pos_next      = byte_pos_reg + 32'd1;
            frame_idx_next     = 3'd0;
            result_next.status = wpsu_pkg::STATUS_UNKNOWN_DEPTH;
        end else if (cfg.audio_format != wpsu_pkg::FORMAT_PCM) begin
            has_result         = 1'b1;
            byte_pos_next      = byte_pos_reg + 32'd1;
            frame_idx_next     = 3'd0;
            result_next.status = wpsu_pkg::STATUS_UNSUPPORTED;
        end else begin
            byte_pos_next = byte_pos_reg + 32'd1;
            if (to_right) begin
                right_hold_next = hold_new;
            end else begin
                left_hold_next = hold_new;
            end
            if (frame_done) begin
                has_result     = 1'b1;
                frame_idx_next = 3'd0;
                // signed samples become offset binary
                left_out  = (sample_bytes == 2'd1) ? left_hold_next
                                                   : left_hold_next ^ wpsu_pkg::SIGN_FLIP;
                right_out = (sample_bytes == 2'd1) ? right_hold_next
                                                   : right_hold_next ^ wpsu_pkg::SIGN_FLIP;
                result_next.left_sample  = left_out;
                result_next.right_sample = stereo ? right_out : left_out;
            end else begin
                frame_idx_next = frame_idx_reg + 3'd1;
            end
        end
    end

    // result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = fire && has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg   <= 32'd0;
            frame_idx_reg  <= 3'd0;
            left_hold_reg  <= 16'd0;
            right_hold_reg <= 16'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                byte_pos_reg   <= byte_pos_next;
                frame_idx_reg  <= frame_idx_next;
                left_hold_reg  <= left_hold_next;
                right_hold_reg <= right_hold_next;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (fire && has_result) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

endmodule

// ===== rtl/wpsu_checker.sv =====
// port-level checks for the wav pcm sample unpacker, bound to the top level
module wpsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // any error status carries zero samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:32] != wpsu_pkg::STATUS_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("error status with nonzero samples");

    // pad bits of the result stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:34] == 6'd0))
        else $error("result pad bits not zero");

    // a ready receiver never stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

endmodule

bind wav_pcm_sample_unpacker wpsu_checker u_wpsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_top.sv =====
// testbench for the wav pcm sample unpacker: directed and random byte streams, scoreboard check
module tb_top;
    import wpsu_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 1100;

    // tracks the header and frame assembly, keeps the frames still to come out
    class frame_scoreboard;
        logic [15:0]  fmt;
        logic [15:0]  chans;
        logic [15:0]  depth;
        logic [31:0]  data_len;
        logic [31:0]  byte_pos;
        logic [2:0]   frame_idx;
        logic [15:0]  left_acc;
        logic [15:0]  right_acc;
        wpsu_result_t expected_frames[$];
        int           mismatch_count;
        int           frames_checked;

        function new();
            fmt            = AUDIO_FORMAT_RST;
            chans          = CHANNEL_COUNT_RST;
            depth          = BITS_PER_SAMPLE_RST;
            data_len       = DATA_LENGTH_RST;
            byte_pos       = '0;
            frame_idx      = '0;
            left_acc       = '0;
            right_acc      = '0;
            mismatch_count = 0;
            frames_checked = 0;
        endfunction

        function void set_register(wpsu_cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_AUDIO_FORMAT:    fmt      = value[15:0];
                CFG_CHANNEL_COUNT:   chans    = value[15:0];
                CFG_BITS_PER_SAMPLE: depth    = value[15:0];
                CFG_DATA_LENGTH:     data_len = value;
                default: ;
            endcase
        endfunction

        function void push_frame(logic [15:0] l, logic [15:0] r, wpsu_status_t st);
            wpsu_result_t res;
            res.left_sample  = l;
            res.right_sample = r;
            res.status       = st;
            expected_frames.push_back(res);
        endfunction

        // one accepted byte or rewind: advance the assembly, queue any frame it finishes
        function void take_byte(logic kind, logic [7:0] b);
            int          n;
            int          frame_len;
            int          k;
            int          off;
            int          part;
            bit          stereo;
            bit          to_right;
            logic [15:0] acc;
            logic [15:0] l;
            logic [15:0] r;
            if (kind == KIND_REWIND) begin
                byte_pos  = '0;
                frame_idx = '0;
                left_acc  = '0;
                right_acc = '0;
                return;
            end
            // past the data chunk: status only, nothing moves
            if (byte_pos >= data_len) begin
                push_frame('0, '0, STATUS_END_OF_DATA);
                return;
            end
            case (depth)
                BPS_8:   n = 1;
                BPS_16:  n = 2;
                BPS_24:  n = 3;
                default: n = 0;
            endcase
            // depth check wins over the format check
            if (n == 0 || fmt != FORMAT_PCM) begin
                byte_pos++;
                frame_idx = '0;
                push_frame('0, '0, (n == 0) ? STATUS_UNKNOWN_DEPTH : STATUS_UNSUPPORTED);
                return;
            end
            stereo    = (chans == CHANNELS_STEREO);
            frame_len = stereo ? 2 * n : n;
            k         = frame_idx;
            off       = k % n;
            to_right  = stereo && (k >= n);
            acc       = to_right ? right_acc : left_acc;
            // 8 bit goes to the top byte, wider samples keep their top two bytes
            if (n == 1) begin
                acc = {b, 8'h00};
            end else begin
                part = off + 2 - n;
                if (part == 0)
                    acc[7:0] = b;
                else if (part == 1)
                    acc[15:8] = b;
            end
            if (to_right)
                right_acc = acc;
            else
                left_acc = acc;
            byte_pos++;
            // frame done once the index reaches or passes the last byte
            if (k + 1 >= frame_len) begin
                frame_idx = '0;
                l = left_acc;
                r = right_acc;
                if (n != 1) begin
                    l = l ^ SIGN_FLIP;
                    r = r ^ SIGN_FLIP;
                end
                if (!stereo)
                    r = l;
                push_frame(l, r, STATUS_OK);
            end else begin
                frame_idx = 3'(k + 1);
            end
        endfunction

        // compare one result transfer with the oldest queued frame
        function void check_frame(logic [39:0] data);
            wpsu_result_t got;
            wpsu_result_t exp_frame;
            got = data[33:0];
            frames_checked++;
            if (expected_frames.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: L %h R %h status %0d",
                             got.left_sample, got.right_sample, got.status);
                mismatch_count++;
                return;
            end
            exp_frame = expected_frames.pop_front();
            if (got.left_sample !== exp_frame.left_sample ||
                got.right_sample !== exp_frame.right_sample ||
                got.status !== exp_frame.status) begin
                if (mismatch_count < 10)
                    $display("result %0d: expected L %h R %h status %0d, got L %h R %h status %0d",
                             frames_checked, exp_frame.left_sample, exp_frame.right_sample,
                             exp_frame.status, got.left_sample, got.right_sample, got.status);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [39:0]            m_tdata;

    frame_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  stall_req     = 1'b0;
    int  item_count    = 0;
    int  header_count  = 0;

    wav_pcm_sample_unpacker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // run limit
    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: check transfers, random backpressure, long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_frame(m_tdata);
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                for (int c = 0; c < STALL_CYCLES; c++)
                    @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // one byte or rewind transfer, with random idle cycles ahead of it
    task automatic send_item(logic kind, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.take_byte(kind, b);
        item_count++;
    endtask

    // stop offering and wait until every queued frame has come out
    task automatic wait_for_frames();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(wpsu_cfg_idx_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_register(idx, value);
    endtask

    // program all four header registers, block must be idle
    task automatic load_header(logic [15:0] fmt, logic [15:0] ch, logic [15:0] bps,
                               logic [31:0] len);
        cfg_write(CFG_AUDIO_FORMAT, {16'h0, fmt});
        cfg_write(CFG_CHANNEL_COUNT, {16'h0, ch});
        cfg_write(CFG_BITS_PER_SAMPLE, {16'h0, bps});
        cfg_write(CFG_DATA_LENGTH, len);
        cfg_we <= 1'b0;
        header_count++;
    endtask

    // main stimulus
    initial begin
        int          random_items;
        int          burst;
        logic [15:0] fmt;
        logic [15:0] ch;
        logic [15:0] bps;
        logic [31:0] len;
        logic        kind;

        sb = new();
        send_idle_pct = 29;
        recv_idle_pct = 60;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset header has zero length: first byte is end of data
        send_item(KIND_DATA, 8'h5A);
        wait_for_frames();

        // stereo 16 bit, extreme samples, rewind in mid-frame
        load_header(FORMAT_PCM, CHANNELS_STEREO, BPS_16, 32'hFFFF_FFFF);
        send_item(KIND_DATA, 8'h12);
        send_item(KIND_REWIND, 8'hFF);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h7F);
        wait_for_frames();

        // stereo 24 bit: low byte dropped, then a partial frame left held
        load_header(FORMAT_PCM, CHANNELS_STEREO, BPS_24, 32'hFFFF_FFFF);
        send_item(KIND_DATA, 8'hAA);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_DATA, 8'hBB);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h7F);
        send_item(KIND_DATA, 8'h11);
        send_item(KIND_DATA, 8'h22);
        send_item(KIND_DATA, 8'h33);
        send_item(KIND_DATA, 8'h44);
        wait_for_frames();

        // header shrinks the frame under a held index: next byte completes it
        load_header(FORMAT_PCM, 16'hFFFF, BPS_16, 32'hFFFF_FFFF);
        send_item(KIND_DATA, 8'h55);
        wait_for_frames();

        // unsupported format, then unknown depths (zero and 32-bit float)
        load_header(16'hFFFF, 16'h0000, BPS_16, 32'hFFFF_FFFF);
        send_item(KIND_DATA, 8'h01);
        wait_for_frames();
        load_header(16'h0000, CHANNELS_STEREO, 16'h0000, 32'hFFFF_FFFF);
        send_item(KIND_DATA, 8'h02);
        wait_for_frames();
        load_header(16'd3, CHANNELS_STEREO, 16'd32, 32'hFFFF_FFFF);
        send_item(KIND_DATA, 8'h03);
        wait_for_frames();

        // mono 8 bit with a short chunk: run off the end, rewind, go again
        load_header(FORMAT_PCM, 16'd1, BPS_8, 32'd3);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_DATA, 8'h7E);
        send_item(KIND_REWIND, 8'h00);
        send_item(KIND_DATA, 8'h81);
        wait_for_frames();

        // random bursts, each under a fresh header
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 29;
                recv_idle_pct = 60;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 60;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (random_items == 0) begin
                // long receiver hold-off while the sender keeps going
                fmt   = FORMAT_PCM;
                ch    = CHANNELS_STEREO;
                bps   = BPS_16;
                len   = 32'hFFFF_FFFF;
                burst = 48;
                stall_req = 1'b1;
            end else begin
                burst = $urandom_range(20, 60);
                if ($urandom_range(0, 9) == 0) begin
                    // malformed header
                    fmt = ($urandom_range(0, 1) == 0) ? 16'($urandom) : FORMAT_PCM;
                    ch  = 16'($urandom);
                    case ($urandom_range(0, 3))
                        0:       bps = 16'($urandom);
                        1:       bps = 16'd32;
                        2:       bps = 16'd0;
                        default: bps = BPS_24;
                    endcase
                end else begin
                    fmt = FORMAT_PCM;
                    ch  = 16'($urandom_range(1, 2));
                    case ($urandom_range(0, 2))
                        0:       bps = BPS_8;
                        1:       bps = BPS_16;
                        default: bps = BPS_24;
                    endcase
                end
                len = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 48)) : $urandom;
            end
            load_header(fmt, ch, bps, len);

            for (int i = 0; i < burst; i++) begin
                kind = ($urandom_range(0, 39) == 0) ? KIND_REWIND : KIND_DATA;
                send_item(kind, 8'($urandom));
                random_items++;
            end
            wait_for_frames();
        end

        $display("%0d byte and rewind transfers under %0d headers, %0d results checked",
                 item_count, header_count, sb.frames_checked);
        $display("covered 8/16/24 bit mono and stereo, end of data, bad format and depth");
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
